@@ src/bpg_pkg.sv @@
package bpg_pkg;

	// field and internal widths
	localparam int TIME_W  = 32;
	localparam int FREQ_W  = 32;
	localparam int OUT_W   = 16;
	localparam int DELAY_W = 45;
	localparam int A_W     = 45;

	// configuration register indexes
	localparam logic REG_MIN_FREQ = 1'b0;
	localparam logic REG_MAX_FREQ = 1'b1;

	// reset values of the band edges
	localparam logic [FREQ_W-1:0] FMIN_RST = 32'd42949673;
	localparam logic [FREQ_W-1:0] FMAX_RST = 32'd214748365;

	// delay = round(20 * 2^40 / fmin), numerator base and reset value
	localparam logic [DELAY_W-1:0] DELAY_BASE = 45'(64'd20 << 40);
	localparam logic [DELAY_W-1:0] DELAY_RST  =
		45'(((64'd20 << 40) + 64'd21474836) / 64'd42949673);

	// fixed-point constants
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [31:0] PI_Q30     = 32'd3373259426;
	localparam logic [76:0] TAIL_LIMIT = 77'd48 << 40;
	localparam int          RND_SH     = 31 - OUT_W;

	// pipeline depths
	localparam int SIN_LAT     = 17;
	localparam int GAUSS_LAT   = 27;
	localparam int DIV_LAT     = 31;
	localparam int BACK_LAT    = 2 + SIN_LAT + DIV_LAT + 3;
	localparam int QUEUE_DEPTH = 4;

	// one classified item between front and back
	typedef struct packed {
		logic [A_W-1:0] a;
		logic           invalid;
	} bpg_item_t;

	// band terms derived from the configuration registers
	typedef struct packed {
		logic [FREQ_W-1:0] fmax;
		logic [FREQ_W-1:0] bw;
		logic [FREQ_W:0]   fs;
	} bpg_cfg_t;

endpackage

@@ src/bandlimited_pulse_generator_core.sv @@
// structure: an accepted time value passes the input register, the queue and a
//   53-stage arithmetic pipeline before its pulse sample is offered at the output
// throughput: one sample per cycle while out_ready is high; a write of min_frequency
//   recomputes the pulse delay with a bit-serial divider and holds in_ready low until it ends
// reset: arst_n clears all valid bits and the queue and loads the register reset values
module bandlimited_pulse_generator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic                             cfg_index,
	input  logic [bpg_pkg::FREQ_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bpg_pkg::TIME_W-1:0]       time_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [bpg_pkg::OUT_W-1:0] pulse_value,
	output logic                             status
);

	logic               push_valid, push_ready, pop_valid, pop_ready;
	bpg_pkg::bpg_item_t push_item, pop_item;
	bpg_pkg::bpg_cfg_t  band;

	// accept, measure distance from the pulse center, classify
	bpg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.time_value (time_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.band       (band)
	);

	// decoupling queue
	bpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// arithmetic pipeline
	bpg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.band        (band),
		.in_valid    (pop_valid),
		.in_ready    (pop_ready),
		.in_item     (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pulse_value (pulse_value),
		.status      (status)
	);

endmodule

@@ src/bpg_front.sv @@
module bpg_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic                              cfg_index,
	input  logic [bpg_pkg::FREQ_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bpg_pkg::TIME_W-1:0]        time_value,
	output logic                              push_valid,
	input  logic                              push_ready,
	output bpg_pkg::bpg_item_t                push_item,
	output bpg_pkg::bpg_cfg_t                 band
);

	logic [bpg_pkg::FREQ_W-1:0]  fmin_q, fmax_q;
	logic [bpg_pkg::DELAY_W-1:0] delay_q, num_q, quo_q;
	logic [bpg_pkg::FREQ_W-1:0]  rem_q;
	logic [5:0]                  cnt_q;
	logic                        busy_q;
	logic                        fr_valid_s1;
	logic [bpg_pkg::TIME_W-1:0]  time_s1;
	logic [bpg_pkg::FREQ_W:0]    rem_sh;
	logic                        rem_ge;
	logic [bpg_pkg::DELAY_W-1:0] t_ext;

	// restoring divide step for the delay, one quotient bit a cycle
	assign rem_sh = {rem_q, num_q[bpg_pkg::DELAY_W-1]};
	assign rem_ge = rem_sh >= {1'b0, fmin_q};

	// configuration registers and delay divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmin_q  <= bpg_pkg::FMIN_RST;
			fmax_q  <= bpg_pkg::FMAX_RST;
			delay_q <= bpg_pkg::DELAY_RST;
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bpg_pkg::REG_MIN_FREQ: begin
					fmin_q <= cfg_data;
					busy_q <= 1'b1;
					cnt_q  <= 6'(bpg_pkg::DELAY_W - 1);
					num_q  <= bpg_pkg::DELAY_BASE +
						bpg_pkg::DELAY_W'(cfg_data[bpg_pkg::FREQ_W-1:1]);
					quo_q  <= '0;
					rem_q  <= '0;
				end
				bpg_pkg::REG_MAX_FREQ: begin
					fmax_q <= cfg_data;
				end
				default: ;
			endcase
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_ge ? bpg_pkg::FREQ_W'(rem_sh - {1'b0, fmin_q})
				: rem_sh[bpg_pkg::FREQ_W-1:0];
			quo_q <= {quo_q[bpg_pkg::DELAY_W-2:0], rem_ge};
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) begin
				busy_q  <= 1'b0;
				delay_q <= {quo_q[bpg_pkg::DELAY_W-2:0], rem_ge};
			end
		end
	end

	// input register
	assign in_ready   = !busy_q && (!fr_valid_s1 || push_ready);
	assign push_valid = fr_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			fr_valid_s1 <= 1'b1;
		end else if (push_ready) begin
			fr_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1 <= time_value;
		end
	end

	// distance from the pulse center and band check
	assign t_ext = bpg_pkg::DELAY_W'(time_s1);

	always_comb begin
		push_item.a = (t_ext >= delay_q) ? t_ext - delay_q : delay_q - t_ext;
		push_item.invalid = (fmin_q == '0) || (fmax_q == '0) || (fmin_q >= fmax_q);
	end

	// band terms for the back end
	always_comb begin
		band.fmax = fmax_q;
		band.bw   = fmax_q - fmin_q;
		band.fs   = {1'b0, fmax_q} + {1'b0, fmin_q};
	end

endmodule

@@ src/bpg_queue.sv @@
module bpg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  bpg_pkg::bpg_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output bpg_pkg::bpg_item_t pop_item
);

	localparam int PW = $clog2(bpg_pkg::QUEUE_DEPTH);

	bpg_pkg::bpg_item_t entry_q [bpg_pkg::QUEUE_DEPTH];
	logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [PW:0]        count_q;
	logic               do_push, do_pop;

	assign push_ready = count_q != (PW+1)'(bpg_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ src/bpg_sin.sv @@
module bpg_sin (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] phase,
	output logic [30:0] mag,
	output logic        neg
);

	localparam int STEPS = 7;

	logic [23:0] q_fold;
	logic [55:0] ang_prod;
	logic [61:0] a2_prod, fin_prod;
	logic [30:0] ang_s1, ang_s2;
	logic        neg_s1, neg_s2;
	logic [31:0] a2_s2;

	logic [31:0] va_q   [STEPS];
	logic [31:0] a2a_q  [STEPS];
	logic [30:0] anga_q [STEPS];
	logic        nega_q [STEPS];
	logic [30:0] rb_q   [STEPS];
	logic [31:0] a2b_q  [STEPS];
	logic [30:0] angb_q [STEPS];
	logic        negb_q [STEPS];

	logic [30:0] mag_q;
	logic        neg_q;

	// fold into a quarter wave and scale to radians
	always_comb begin
		q_fold = phase[23:0];
		if (phase[23:0] > 24'h80_0000) begin
			q_fold = 24'(25'h100_0000 - {1'b0, phase[23:0]});
		end
	end

	assign ang_prod = 56'(q_fold) * 56'(bpg_pkg::PI_Q30);
	assign a2_prod  = 62'(ang_s1) * 62'(ang_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1 <= ang_prod[54:24];
			neg_s1 <= phase[24];
			a2_s2  <= a2_prod[61:30];
			ang_s2 <= ang_s1;
			neg_s2 <= neg_s1;
		end
	end

	// taylor series, one multiply and one constant divide per term
	for (genvar j = 0; j < STEPS; j++) begin : g_term
		localparam int unsigned KK = STEPS - j;
		localparam int unsigned DV = (2 * KK) * (2 * KK + 1);
		localparam int unsigned LV = $clog2(DV);
		localparam logic [32:0] MV =
			33'(((64'd1 << (32 + LV)) + 64'(DV) - 64'd1) / 64'(DV));

		logic [31:0] a2_in;
		logic [30:0] r_in, ang_in;
		logic        neg_in;
		logic [62:0] vprod;
		logic [64:0] qprod, qsh;

		if (j == 0) begin : g_first
			assign a2_in  = a2_s2;
			assign r_in   = bpg_pkg::ONE_Q30;
			assign ang_in = ang_s2;
			assign neg_in = neg_s2;
		end else begin : g_next
			assign a2_in  = a2b_q[j-1];
			assign r_in   = rb_q[j-1];
			assign ang_in = angb_q[j-1];
			assign neg_in = negb_q[j-1];
		end

		assign vprod = 63'(a2_in) * 63'(r_in);
		assign qprod = 65'(va_q[j]) * 65'(MV);
		assign qsh   = qprod >> (32 + LV);

		always_ff @(posedge clk) begin
			if (en) begin
				va_q[j]   <= vprod[61:30];
				a2a_q[j]  <= a2_in;
				anga_q[j] <= ang_in;
				nega_q[j] <= neg_in;
				rb_q[j]   <= bpg_pkg::ONE_Q30 - qsh[30:0];
				a2b_q[j]  <= a2a_q[j];
				angb_q[j] <= anga_q[j];
				negb_q[j] <= nega_q[j];
			end
		end
	end

	// final multiply by the angle
	assign fin_prod = 62'(angb_q[STEPS-1]) * 62'(rb_q[STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= fin_prod[60:30];
			neg_q <= negb_q[STEPS-1];
		end
	end

	assign mag = mag_q;
	assign neg = neg_q;

endmodule

@@ src/bpg_back.sv @@
module bpg_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bpg_pkg::bpg_cfg_t                band,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bpg_pkg::bpg_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [bpg_pkg::OUT_W-1:0] pulse_value,
	output logic                             status
);

	localparam int GTERMS   = 10;
	localparam int GD_LEN   = bpg_pkg::SIN_LAT + bpg_pkg::DIV_LAT - bpg_pkg::GAUSS_LAT;
	localparam int FLAG_LEN = bpg_pkg::SIN_LAT + bpg_pkg::DIV_LAT;
	localparam int DEN_LEN  = bpg_pkg::SIN_LAT - 1;
	localparam int COS_LEN  = bpg_pkg::DIV_LAT;
	localparam int RW       = 34 - bpg_pkg::RND_SH;

	typedef struct packed {
		logic tail;
		logic invalid;
		logic szero;
	} flags_t;

	logic en;
	logic v_q [bpg_pkg::BACK_LAT];

	// global advance: the last stage is the output register
	assign en        = !v_q[bpg_pkg::BACK_LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[bpg_pkg::BACK_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bpg_pkg::BACK_LAT; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < bpg_pkg::BACK_LAT; i++) v_q[i] <= v_q[i-1];
		end
	end

	// stage 1: partial products of the distance with the band terms
	logic [63:0] pf_lo_s1, pb_lo_s1;
	logic [44:0] pf_hi_s1, pb_hi_s1;
	logic [64:0] ps_lo_s1;
	logic [45:0] ps_hi_s1;
	logic        inv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pf_lo_s1 <= 64'(in_item.a[31:0]) * 64'(band.fmax);
			pf_hi_s1 <= 45'(in_item.a[44:32]) * 45'(band.fmax);
			pb_lo_s1 <= 64'(in_item.a[31:0]) * 64'(band.bw);
			pb_hi_s1 <= 45'(in_item.a[44:32]) * 45'(band.bw);
			ps_lo_s1 <= 65'(in_item.a[31:0]) * 65'(band.fs);
			ps_hi_s1 <= 46'(in_item.a[44:32]) * 46'(band.fs);
			inv_s1   <= in_item.invalid;
		end
	end

	// stage 2: gaussian argument, tail test and the two phases
	logic [76:0] p_full;
	logic [75:0] s_full;
	logic [77:0] c_full;
	logic [25:0] u20_s2;
	logic [29:0] s_s2;
	logic [31:0] cph_s2;
	flags_t      flags_s2;

	assign p_full = 77'(pf_lo_s1) + (77'(pf_hi_s1) << 32);
	assign s_full = 76'(pb_lo_s1) + (76'(pb_hi_s1) << 32);
	assign c_full = 78'(ps_lo_s1) + (78'(ps_hi_s1) << 32);

	always_ff @(posedge clk) begin
		if (en) begin
			u20_s2           <= p_full[45:20];
			s_s2             <= s_full[45:16];
			cph_s2           <= 32'(c_full[46:16]) + 32'h0080_0000;
			flags_s2.tail    <= p_full >= bpg_pkg::TAIL_LIMIT;
			flags_s2.invalid <= inv_s1;
			flags_s2.szero   <= s_full[45:16] == '0;
		end
	end

	// sine of the sinc phase and cosine of the carrier phase
	logic [30:0] sm, cm;
	logic        sneg, cneg;

	bpg_sin u_sin_s (
		.clk   (clk),
		.en    (en),
		.phase (32'(s_s2)),
		.mag   (sm),
		.neg   (sneg)
	);

	bpg_sin u_sin_c (
		.clk   (clk),
		.en    (en),
		.phase (cph_s2),
		.mag   (cm),
		.neg   (cneg)
	);

	// sinc denominator, aligned with the sine output
	logic [61:0] den_prod;
	logic [37:0] den_s3;
	logic [37:0] den_d_q [DEN_LEN];

	assign den_prod = 62'(s_s2) * 62'(bpg_pkg::PI_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3     <= den_prod[61:24];
			den_d_q[0] <= den_s3;
			for (int i = 1; i < DEN_LEN; i++) den_d_q[i] <= den_d_q[i-1];
		end
	end

	// sinc divider, one quotient bit per stage
	logic [60:0] dv_rem_q [bpg_pkg::DIV_LAT];
	logic [37:0] dv_den_q [bpg_pkg::DIV_LAT];
	logic [30:0] dv_quo_q [bpg_pkg::DIV_LAT];

	for (genvar i = 0; i < bpg_pkg::DIV_LAT; i++) begin : g_div
		localparam int BIT = bpg_pkg::DIV_LAT - 1 - i;

		logic [60:0] rem_in;
		logic [37:0] den_in;
		logic [30:0] quo_in;
		logic [68:0] dsh;
		logic        ge;

		if (i == 0) begin : g_first
			assign rem_in = {sm, 30'b0};
			assign den_in = den_d_q[DEN_LEN-1];
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = dv_rem_q[i-1];
			assign den_in = dv_den_q[i-1];
			assign quo_in = dv_quo_q[i-1];
		end

		assign dsh = 69'(den_in) << BIT;
		assign ge  = 69'(rem_in) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_q[i] <= ge ? rem_in - dsh[60:0] : rem_in;
				dv_den_q[i] <= den_in;
				dv_quo_q[i] <= quo_in | (31'(ge) << BIT);
			end
		end
	end

	// gaussian: z = u20^2 / 3276800 by shift and reciprocal of 25
	localparam logic [35:0] M25 = 36'(((64'd1 << 40) + 64'd24) / 64'd25);

	logic [51:0] usq;
	logic [34:0] x_s3;
	logic [63:0] pp0_s4;
	logic [35:0] pp1_s4;
	logic [34:0] pp2_s4;
	logic [6:0]  pp3_s4;
	logic [71:0] zsum;
	logic [29:0] z_s5;

	assign usq  = 52'(u20_s2) * 52'(u20_s2);
	assign zsum = 72'(pp0_s4) + (72'(pp1_s4) << 32) + (72'(pp2_s4) << 32)
		+ (72'(pp3_s4) << 64);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3   <= usq[51:17];
			pp0_s4 <= 64'(x_s3[31:0]) * 64'(M25[31:0]);
			pp1_s4 <= 36'(x_s3[31:0]) * 36'(M25[35:32]);
			pp2_s4 <= 35'(x_s3[34:32]) * 35'(M25[31:0]);
			pp3_s4 <= 7'(x_s3[34:32]) * 7'(M25[35:32]);
			z_s5   <= zsum[69:40];
		end
	end

	// exponential series, one multiply and one constant divide per term
	logic [29:0] gza_q [GTERMS];
	logic [29:0] gva_q [GTERMS];
	logic [29:0] gzb_q [GTERMS];
	logic [30:0] grb_q [GTERMS];

	for (genvar j = 0; j < GTERMS; j++) begin : g_exp
		localparam int unsigned KK = GTERMS - j;
		localparam int unsigned LV = $clog2(KK);
		localparam logic [32:0] MV =
			33'(((64'd1 << (32 + LV)) + 64'(KK) - 64'd1) / 64'(KK));

		logic [29:0] z_in;
		logic [30:0] r_in;
		logic [60:0] vprod;
		logic [64:0] qprod, qsh;

		if (j == 0) begin : g_first
			assign z_in = z_s5;
			assign r_in = bpg_pkg::ONE_Q30;
		end else begin : g_next
			assign z_in = gzb_q[j-1];
			assign r_in = grb_q[j-1];
		end

		assign vprod = 61'(z_in) * 61'(r_in);
		assign qprod = 65'(gva_q[j]) * 65'(MV);
		assign qsh   = qprod >> (32 + LV);

		always_ff @(posedge clk) begin
			if (en) begin
				gva_q[j] <= vprod[59:30];
				gza_q[j] <= z_in;
				gzb_q[j] <= gza_q[j];
				grb_q[j] <= bpg_pkg::ONE_Q30 - qsh[30:0];
			end
		end
	end

	// four squarings take exp(-z) to exp(-16 z)
	logic [30:0] gs_q [4];

	for (genvar k = 0; k < 4; k++) begin : g_sq
		logic [30:0] r_in;
		logic [61:0] sq;

		if (k == 0) begin : g_first
			assign r_in = grb_q[GTERMS-1];
		end else begin : g_next
			assign r_in = gs_q[k-1];
		end

		assign sq = 62'(r_in) * 62'(r_in);

		always_ff @(posedge clk) begin
			if (en) begin
				gs_q[k] <= sq[60:30];
			end
		end
	end

	// alignment delays up to the divider output
	logic [30:0] gd_q    [GD_LEN];
	logic [30:0] cmd_q   [COS_LEN];
	logic        cnegd_q [COS_LEN];
	logic        snegd_q [COS_LEN];
	flags_t      fd_q    [FLAG_LEN];

	always_ff @(posedge clk) begin
		if (en) begin
			gd_q[0]    <= gs_q[3];
			cmd_q[0]   <= cm;
			cnegd_q[0] <= cneg;
			snegd_q[0] <= sneg;
			fd_q[0]    <= flags_s2;
			for (int i = 1; i < GD_LEN; i++) gd_q[i] <= gd_q[i-1];
			for (int i = 1; i < COS_LEN; i++) begin
				cmd_q[i]   <= cmd_q[i-1];
				cnegd_q[i] <= cnegd_q[i-1];
				snegd_q[i] <= snegd_q[i-1];
			end
			for (int i = 1; i < FLAG_LEN; i++) fd_q[i] <= fd_q[i-1];
		end
	end

	// product of the three terms
	logic [30:0] sinc_sel;
	logic [61:0] m1_prod;
	logic [62:0] m2_prod;
	logic [31:0] mag1_c1;
	logic [32:0] mag2_c2;
	logic [30:0] cm_c1;
	logic        neg_c1, neg_c2;
	flags_t      fl_c1, fl_c2;

	assign sinc_sel = fd_q[FLAG_LEN-1].szero ? bpg_pkg::ONE_Q30
		: dv_quo_q[bpg_pkg::DIV_LAT-1];
	assign m1_prod  = 62'(sinc_sel) * 62'(gd_q[GD_LEN-1]);
	assign m2_prod  = 63'(mag1_c1) * 63'(cm_c1);

	always_ff @(posedge clk) begin
		if (en) begin
			mag1_c1 <= m1_prod[61:30];
			cm_c1   <= cmd_q[COS_LEN-1];
			neg_c1  <= snegd_q[COS_LEN-1] != cnegd_q[COS_LEN-1];
			fl_c1   <= fd_q[FLAG_LEN-1];
			mag2_c2 <= m2_prod[62:30];
			neg_c2  <= neg_c1;
			fl_c2   <= fl_c1;
		end
	end

	// round the magnitude half up, saturate, apply sign, zero invalid and tail samples
	logic [33:0]                  rsum;
	logic [RW-1:0]                rmag, lim, sat;
	logic [bpg_pkg::OUT_W-1:0]    res;
	logic [bpg_pkg::OUT_W-1:0]    pulse_c3;
	logic                         status_c3;

	always_comb begin
		rsum = 34'(mag2_c2) + (34'd1 << (bpg_pkg::RND_SH - 1));
		rmag = rsum[33:bpg_pkg::RND_SH];
		lim  = (RW'(1) << (bpg_pkg::OUT_W - 1)) - (neg_c2 ? RW'(0) : RW'(1));
		sat  = (rmag > lim) ? lim : rmag;
		res  = neg_c2 ? bpg_pkg::OUT_W'(RW'(0) - sat) : bpg_pkg::OUT_W'(sat);
		if (fl_c2.invalid || fl_c2.tail) res = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pulse_c3  <= res;
			status_c3 <= fl_c2.invalid;
		end
	end

	assign pulse_value = signed'(pulse_c3);
	assign status      = status_c3;

endmodule

@@ src/bpg_checker.sv @@
module bpg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_write,
	input logic                             cfg_index,
	input logic [bpg_pkg::FREQ_W-1:0]       cfg_data,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [bpg_pkg::TIME_W-1:0]       time_value,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [bpg_pkg::OUT_W-1:0] pulse_value,
	input logic                             status
);

	// an invalid band always comes with a zero sample
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> pulse_value == '0)
		else $error("status set with nonzero pulse_value");

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pulse_value) && $stable(status))
		else $error("output transaction changed while stalled");

	// a new lower band edge blocks input while the delay is recomputed
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && cfg_index == bpg_pkg::REG_MIN_FREQ |=> !in_ready)
		else $error("input accepted during delay recompute");

endmodule

bind bandlimited_pulse_generator_core bpg_checker u_bpg_checker (.*);
